@@ rtl/sgr_pkg.sv @@
// Shared types and constants of the 3x3 Sobel gradient block.
`timescale 1ns / 1ps
package sgr_pkg;

   localparam int PIX_W      = 8;
   localparam int GRAD_W     = 11;
   localparam int IMG_W_W    = 11;
   localparam int IMG_H_W    = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

   // per-item control that travels from the front counters to the window stage
   typedef struct packed {
      logic primed;     // item produces a result
      logic col_zero;   // item sits in column 0 of the input raster
      logic l_mask;     // result pixel is in the first column
      logic r_mask;     // result pixel is in the last column
      logic t_mask;     // result pixel is in the first row
      logic b_mask;     // result pixel is in the last row
      logic last;       // result pixel is the final pixel of the frame
   } sgr_tag_type;

endpackage

@@ rtl/sgr_line_store.sv @@
// Two-row line store: one synchronous memory holding {upper, middle} per column.
`timescale 1ns / 1ps
module sgr_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   output logic [15:0]   rd_data
);
   logic [15:0] line_mem_ff [DEPTH];
   logic [15:0] q_ff;
   logic        fwd_ff;
   logic        fwd_in;
   logic [15:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff        <= line_mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // a read that meets a write to the same column takes the new word
   assign fwd_in = rd_en ? (wr_en && (wr_addr == rd_addr)) : fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : q_ff;

   a_forward: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data))
      else $error("line store forwarding lost a same-column write");

endmodule

@@ rtl/sgr_frame_ctrl.sv @@
// Frame geometry registers and input/output raster position counters.
`timescale 1ns / 1ps
module sgr_frame_ctrl #(
   parameter int MAX_WIDTH = 1024,
   parameter int COL_W     = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [sgr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sgr_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            accept,
   output logic [COL_W-1:0]                col,
   output sgr_pkg::sgr_tag_type            tag
);
   import sgr_pkg::*;

   localparam logic [1:0] ROW_SAT = 2'd2;

   logic [IMG_W_W-1:0] image_width_ff;
   logic [IMG_H_W-1:0] image_height_ff;
   logic [COL_W-1:0]   in_col_ff,  in_col_in;
   logic [1:0]         in_row_ff,  in_row_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic [IMG_H_W-1:0] out_row_ff, out_row_in;
   logic [COL_W-1:0]   last_col;
   logic [IMG_H_W-1:0] last_row;
   logic               in_col_end;

   always_comb begin
      if (image_width_ff == '0) begin
         last_col = '0;
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_W'(image_width_ff - IMG_W_W'(1));
      end
      last_row = (image_height_ff == '0) ? '0 : image_height_ff - IMG_H_W'(1);
   end

   assign col        = in_col_ff;
   assign in_col_end = (in_col_ff == last_col);

   always_comb begin
      tag.primed   = (in_row_ff == ROW_SAT) || ((in_row_ff == 2'd1) && (in_col_ff != '0));
      tag.col_zero = (in_col_ff == '0);
      tag.l_mask   = (out_col_ff == '0);
      tag.r_mask   = (out_col_ff == last_col);
      tag.t_mask   = (out_row_ff == '0);
      tag.b_mask   = (out_row_ff == last_row);
      tag.last     = tag.r_mask && tag.b_mask;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_we) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept) begin
         if (in_col_end) begin
            in_col_in = '0;
            in_row_in = (in_row_ff == ROW_SAT) ? ROW_SAT : in_row_ff + 2'd1;
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (tag.primed) begin
            if (tag.last) begin
               // frame done: next item is pixel 0 of a new frame
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (tag.r_mask) begin
               out_col_in = '0;
               out_row_in = out_row_ff + IMG_H_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
      end else begin
         if (csr_we && (csr_index == CSR_IMAGE_WIDTH)) begin
            image_width_ff <= csr_data[IMG_W_W-1:0];
         end
         if (csr_we && (csr_index == CSR_IMAGE_HEIGHT)) begin
            image_height_ff <= csr_data;
         end
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_we && tag.primed && tag.last |=>
         (in_col_ff == '0) && (in_row_ff == '0) && (out_col_ff == '0) && (out_row_ff == '0))
      else $error("counters did not restart after the last pixel of a frame");

endmodule

@@ rtl/sgr_window.sv @@
// 3x3 window columns, edge masking, Sobel kernels and the result register.
`timescale 1ns / 1ps
module sgr_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              shift,
   input  logic                              load,
   input  sgr_pkg::sgr_tag_type              tag,
   input  logic [sgr_pkg::PIX_W-1:0]         up,
   input  logic [sgr_pkg::PIX_W-1:0]         mid,
   input  logic [sgr_pkg::PIX_W-1:0]         pix,
   output logic signed [sgr_pkg::GRAD_W-1:0] grad_x,
   output logic signed [sgr_pkg::GRAD_W-1:0] grad_y,
   output logic                              last_of_frame
);
   import sgr_pkg::*;

   // index 0 top, 1 middle, 2 bottom; col1 is the older of the two kept columns
   logic [PIX_W-1:0] col1_ff [3];
   logic [PIX_W-1:0] col2_ff [3];
   logic [PIX_W-1:0] fresh [3];
   logic signed [GRAD_W:0] lv [3];
   logic signed [GRAD_W:0] cv [3];
   logic signed [GRAD_W:0] rv [3];
   logic signed [GRAD_W:0] gx, gy;
   logic signed [GRAD_W-1:0] grad_x_ff, grad_y_ff;
   logic                     last_ff;

   assign fresh[0] = up;
   assign fresh[1] = mid;
   assign fresh[2] = pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            col1_ff[r] <= '0;
            col2_ff[r] <= '0;
         end
      end else if (shift) begin
         for (int r = 0; r < 3; r++) begin
            col1_ff[r] <= col2_ff[r];
            col2_ff[r] <= fresh[r];
         end
      end
   end

   // at column 0 the pending result is the last pixel of the row before,
   // so its right neighbor lies outside the frame
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         lv[r] = $signed({4'd0, col1_ff[r]});
         cv[r] = $signed({4'd0, col2_ff[r]});
         rv[r] = tag.col_zero ? '0 : $signed({4'd0, fresh[r]});
      end
      if (tag.l_mask) begin
         for (int r = 0; r < 3; r++) lv[r] = '0;
      end
      if (tag.r_mask) begin
         for (int r = 0; r < 3; r++) rv[r] = '0;
      end
      if (tag.t_mask) begin
         lv[0] = '0;
         cv[0] = '0;
         rv[0] = '0;
      end
      if (tag.b_mask) begin
         lv[2] = '0;
         cv[2] = '0;
         rv[2] = '0;
      end
      gx = (rv[0] - lv[0]) + ((rv[1] - lv[1]) <<< 1) + (rv[2] - lv[2]);
      gy = (lv[2] - lv[0]) + ((cv[2] - cv[0]) <<< 1) + (rv[2] - rv[0]);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grad_x_ff <= gx[GRAD_W-1:0];
         grad_y_ff <= gy[GRAD_W-1:0];
         last_ff   <= tag.last;
      end
   end

   assign grad_x        = grad_x_ff;
   assign grad_y        = grad_y_ff;
   assign last_of_frame = last_ff;

endmodule

@@ rtl/sobel_gradient_3x3_core.sv @@
// Streaming 3x3 Sobel gradient: top level with the item pipeline and handshakes.
//
// Usage:
//   Pixels enter on req_ in raster order, one item per req_valid/req_ready
//   handshake. After the last pixel of a frame the host sends image_width + 1
//   items with req_flush set; they count as zero pixels past the frame.
//   Results leave on rsp_: grad_x and grad_y in two's complement, and
//   rsp_last_of_frame on the final pixel of the frame.
//   csr_ writes set image_width (index 0) and image_height (index 1) and restart
//   the frame; write only while no item is in flight. csr_ready is always high.
// Timing:
//   Pipeline of accept/line-store read, window update/write-back, result
//   register. An item that completes a neighborhood passes the window stage
//   and result registers; a frame's first image_width + 1 items give none.
//   One item per cycle sustained, set by the single read and write port of
//   the line store memory, with forwarding when both touch one column.
//   A stalled rsp_ side holds the result register; the window stage holds
//   and req_ready drops only when a new result meets a full result register.
// Reset: counters restart at pixel 0, geometry returns to 640 x 480, the
//   window clears. Line store contents are not cleared; they never reach a
//   result before being written.
`timescale 1ns / 1ps
module sobel_gradient_3x3_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sgr_pkg::PIX_W-1:0]           req_pixel,
   input  logic                                req_flush,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [sgr_pkg::GRAD_W-1:0]   rsp_grad_x,
   output logic signed [sgr_pkg::GRAD_W-1:0]   rsp_grad_y,
   output logic                                rsp_last_of_frame,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sgr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sgr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import sgr_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic             req_fire;
   logic             csr_we;
   logic [COL_W-1:0] col;
   sgr_tag_type      tag;

   logic             s1_valid_ff, s1_valid_in;
   sgr_tag_type      s1_tag_ff;
   logic [COL_W-1:0] s1_addr_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic             s1_fire;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rd_data;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // stage 1 moves unless its result meets a full, stalled result register
   assign s1_fire   = s1_valid_ff && (!s1_tag_ff.primed || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   sgr_frame_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (req_fire),
      .col       (col),
      .tag       (tag)
   );

   sgr_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (COL_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (col),
      .wr_en   (s1_fire),
      .wr_addr (s1_addr_ff),
      .wr_data ({rd_data[PIX_W-1:0], s1_pixel_ff}),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_tag_ff.primed) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_tag_ff   <= tag;
         s1_addr_ff  <= col;
         s1_pixel_ff <= req_flush ? '0 : req_pixel;
      end
   end

   sgr_window u_window (
      .clock         (clock),
      .reset         (reset),
      .shift         (s1_fire),
      .load          (s1_fire && s1_tag_ff.primed),
      .tag           (s1_tag_ff),
      .up            (rd_data[15:PIX_W]),
      .mid           (rd_data[PIX_W-1:0]),
      .pix           (s1_pixel_ff),
      .grad_x        (rsp_grad_x),
      .grad_y        (rsp_grad_y),
      .last_of_frame (rsp_last_of_frame)
   );

   assign rsp_valid = rsp_valid_ff;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && (s1_addr_ff == $past(s1_addr_ff)))
      else $error("window stage item moved while stalled");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready && s1_valid_ff && s1_tag_ff.primed |=> s1_valid_ff)
      else $error("pending item dropped while result register was full");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !$past(s1_fire && s1_tag_ff.primed) && !reset && !$past(reset) |->
         !rsp_valid)
      else $error("result shown without a window stage item behind it");

endmodule

@@ dv/tb_sobel_gradient_3x3_core.sv @@
// Self-checking testbench for the streaming 3x3 Sobel gradient core.
`timescale 1ns / 1ps
module tb_sobel_gradient_3x3_core;
   import sgr_pkg::*;

   localparam int MAX_W         = 1024;
   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 12;

   typedef enum int { IDLE_NONE, IDLE_FULL, IDLE_SPARSE } idle_mode_type;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             flush;
   } pixel_item_type;

   typedef struct {
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic                     last;
   } grad_item_type;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   logic [PIX_W-1:0]         req_pixel   = '0;
   logic                     req_flush   = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b1;
   logic signed [GRAD_W-1:0] rsp_grad_x;
   logic signed [GRAD_W-1:0] rsp_grad_y;
   logic                     rsp_last_of_frame;
   logic                     csr_valid   = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index   = '0;
   logic [CSR_DATA_W-1:0]    csr_data    = '0;

   sobel_gradient_3x3_core #(.MAX_WIDTH(MAX_W)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel         (req_pixel),
      .req_flush         (req_flush),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_grad_x        (rsp_grad_x),
      .rsp_grad_y        (rsp_grad_y),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------- predictor
   logic [IMG_W_W-1:0] cfg_width  = IMAGE_WIDTH_RESET;
   logic [IMG_H_W-1:0] cfg_height = IMAGE_HEIGHT_RESET;
   logic [PIX_W-1:0]   row_above [MAX_W];
   logic [PIX_W-1:0]   row_prev  [MAX_W];
   logic [PIX_W-1:0]   win       [9] = '{default: '0};
   int                 in_col  = 0;
   int                 in_row  = 0;
   int                 out_col = 0;
   int                 out_row = 0;

   grad_item_type grad_q[$];

   task automatic sobel_step(input logic [PIX_W-1:0] pix, input logic flush);
      int               w, h, ic, r, gx, gy;
      int               col_l[3], col_c[3], col_r[3];
      logic [PIX_W-1:0] p, up, mid;
      logic             primed, last;
      grad_item_type    res;
      w  = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : int'(cfg_width));
      h  = (cfg_height == 0) ? 1 : int'(cfg_height);
      ic = in_col;
      p  = flush ? '0 : pix;
      primed = (in_row >= 2) || (in_row == 1 && ic >= 1);
      // a row start completes the last column of the row before
      if (ic == 0) begin
         for (r = 0; r < 3; r++) begin
            col_l[r] = win[r*3+1];
            col_c[r] = win[r*3+2];
            col_r[r] = 0;
         end
      end
      up  = row_above[ic];
      mid = row_prev[ic];
      row_above[ic] = mid;
      row_prev[ic]  = p;
      for (r = 0; r < 3; r++) begin
         win[r*3]   = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = p;
      if (ic != 0) begin
         for (r = 0; r < 3; r++) begin
            col_l[r] = win[r*3];
            col_c[r] = win[r*3+1];
            col_r[r] = win[r*3+2];
         end
      end
      if (ic + 1 >= w) begin
         in_col = 0;
         in_row++;
      end else begin
         in_col = ic + 1;
      end
      if (!primed) return;

      if (out_col == 0) for (r = 0; r < 3; r++) col_l[r] = 0;
      if (out_col + 1 >= w) for (r = 0; r < 3; r++) col_r[r] = 0;
      if (out_row == 0) begin
         col_l[0] = 0;
         col_c[0] = 0;
         col_r[0] = 0;
      end
      if (out_row + 1 >= h) begin
         col_l[2] = 0;
         col_c[2] = 0;
         col_r[2] = 0;
      end
      gx = (col_r[0] - col_l[0]) + 2 * (col_r[1] - col_l[1]) + (col_r[2] - col_l[2]);
      gy = (col_l[2] - col_l[0]) + 2 * (col_c[2] - col_c[0]) + (col_r[2] - col_r[0]);
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.gx   = gx[GRAD_W-1:0];
      res.gy   = gy[GRAD_W-1:0];
      res.last = last;
      grad_q.push_back(res);

      if (last) begin
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endtask

   // ------------------------------------------------------------ pixel driver
   pixel_item_type pixel_q[$];
   int             items_queued   = 0;
   int             items_accepted = 0;
   int unsigned    req_gap_left   = 0;
   int unsigned    rsp_stall_left = 0;
   idle_mode_type  req_mode       = IDLE_NONE;
   idle_mode_type  rsp_mode       = IDLE_NONE;

   function automatic int unsigned draw_wait(input idle_mode_type mode);
      case (mode)
         IDLE_FULL:   return $urandom_range(0, 13);
         IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
         default:     return 0;
      endcase
   endfunction

   always @(posedge clock) begin : drive_pixels
      pixel_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_gap_left != 0) begin
            req_valid    <= 1'b0;
            req_gap_left <= req_gap_left - 1;
         end else if (pixel_q.size() != 0) begin
            nxt = pixel_q.pop_front();
            req_valid    <= 1'b1;
            req_pixel    <= nxt.pixel;
            req_flush    <= nxt.flush;
            req_gap_left <= draw_wait(req_mode);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : drive_rsp_ready
      int unsigned n;
      if (reset) begin
         rsp_ready      <= 1'b1;
         rsp_stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         n = draw_wait(rsp_mode);
         rsp_ready      <= (n == 0);
         rsp_stall_left <= n;
      end else if (rsp_stall_left > 1) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_ready      <= 1'b1;
         rsp_stall_left <= 0;
      end
   end

   // ---------------------------------------------------------------- monitor
   int fail_count   = 0;
   int stall_cycles = 0;

   always @(posedge clock) begin : watch_ports
      grad_item_type want;
      logic          moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index)
               CSR_IMAGE_WIDTH:  cfg_width  = csr_data[IMG_W_W-1:0];
               CSR_IMAGE_HEIGHT: cfg_height = csr_data[IMG_H_W-1:0];
               default:          ;
            endcase
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            items_accepted++;
            sobel_step(req_pixel, req_flush);
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (grad_q.size() == 0) begin
               $error("unexpected result: grad_x %0d grad_y %0d last_of_frame %0b",
                      rsp_grad_x, rsp_grad_y, rsp_last_of_frame);
               fail_count++;
            end else begin
               want = grad_q.pop_front();
               if (rsp_grad_x !== want.gx) begin
                  $error("grad_x: expected %0d, got %0d", want.gx, rsp_grad_x);
                  fail_count++;
               end
               if (rsp_grad_y !== want.gy) begin
                  $error("grad_y: expected %0d, got %0d", want.gy, rsp_grad_y);
                  fail_count++;
               end
               if (rsp_last_of_frame !== want.last) begin
                  $error("last_of_frame: expected %0b, got %0b", want.last,
                         rsp_last_of_frame);
                  fail_count++;
               end
            end
         end
         if (moved) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_sobel_gradient_3x3_core: FAIL");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------- stimulus
   task automatic push_pixel(input logic [PIX_W-1:0] pixel, input logic flush);
      pixel_item_type it;
      it.pixel = pixel;
      it.flush = flush;
      pixel_q.push_back(it);
      items_queued++;
   endtask

   // one frame of random content followed by its flush items, cut after n_items
   task automatic push_frame(input int w, input int h, input int n_items);
      int               k;
      logic [PIX_W-1:0] px;
      for (k = 0; k < w * h + w + 1 && k < n_items; k++) begin
         if ($urandom_range(0, 3) == 0) px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else px = $urandom_range(0, 255);
         if (k < w * h) push_pixel(px, $urandom_range(0, 31) == 0);
         else push_pixel(px, 1'b1);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // writes both registers in random order; width gets junk in its unused bits
   task automatic set_geometry(input int raw_w, input int raw_h,
                               output int eff_w, output int eff_h);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] hdata;
      wdata = $urandom_range(0, 16'hFFFF);
      wdata[IMG_W_W-1:0] = raw_w[IMG_W_W-1:0];
      hdata = raw_h[IMG_H_W-1:0];
      if ($urandom_range(0, 1)) begin
         write_csr(CSR_IMAGE_WIDTH, wdata);
         write_csr(CSR_IMAGE_HEIGHT, hdata);
      end else begin
         write_csr(CSR_IMAGE_HEIGHT, hdata);
         write_csr(CSR_IMAGE_WIDTH, wdata);
      end
      eff_w = (raw_w[IMG_W_W-1:0] == 0) ? 1 :
              ((raw_w[IMG_W_W-1:0] > MAX_W) ? MAX_W : int'(raw_w[IMG_W_W-1:0]));
      eff_h = (hdata == 0) ? 1 : int'(hdata);
   endtask

   // everything sent and answered, then room for items still in the pipe
   task automatic settle();
      while (items_accepted != items_queued || grad_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int   k, r, c, kind, w, h, raw_w, raw_h, frames, f, n, rand_items;
      logic hot;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: first row and the head of the second
      rsp_mode = IDLE_SPARSE;
      for (k = 0; k < 660; k++) push_pixel(((k / 2) % 2) ? 8'hFF : 8'h00, k == 5);
      settle();

      // 3x3 frames with a hot edge on each side give the gradient extremes
      set_geometry(3, 3, w, h);
      req_mode = IDLE_FULL;
      for (kind = 0; kind < 4; kind++) begin
         for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
               case (kind)
                  0:       hot = (c == 2);
                  1:       hot = (c == 0);
                  2:       hot = (r == 2);
                  default: hot = (r == 0);
               endcase
               // flush inside the frame: its pixel value must not leak
               if (kind == 0 && r == 1 && c == 1) push_pixel(8'hFF, 1'b1);
               else push_pixel(hot ? 8'hFF : 8'h00, 1'b0);
            end
         end
         for (k = 0; k < 4; k++) push_pixel(8'h5A, 1'b1);
      end
      settle();

      // zero width and zero height act as one; two frames back to back
      set_geometry(0, 0, w, h);
      push_frame(w, h, w * h + w + 1);
      push_frame(w, h, w * h + w + 1);
      settle();

      // tallest setting, one column, streamed without gaps; the frame breaks off
      req_mode = IDLE_NONE;
      rsp_mode = IDLE_NONE;
      set_geometry(1, 65535, w, h);
      push_frame(w, h, 40);
      settle();

      rand_items = 0;
      while (rand_items < 300) begin
         req_mode = idle_mode_type'($urandom_range(0, 2));
         rsp_mode = idle_mode_type'($urandom_range(0, 2));
         case ($urandom_range(0, 9))
            0:       raw_w = 0;
            1:       raw_w = $urandom_range(1, 2);
            default: raw_w = $urandom_range(1, 12);
         endcase
         raw_h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         set_geometry(raw_w, raw_h, w, h);
         frames = $urandom_range(1, 3);
         for (f = 0; f < frames; f++) begin
            n = w * h + w + 1;
            // now and then the last frame breaks off before it is complete
            if (f == frames - 1 && $urandom_range(0, 3) == 0) n = $urandom_range(1, n - 1);
            push_frame(w, h, n);
            rand_items += n;
         end
         settle();
      end

      if (fail_count == 0 && grad_q.size() == 0) begin
         $display("tb_sobel_gradient_3x3_core: PASS");
      end else begin
         $display("tb_sobel_gradient_3x3_core: FAIL");
      end
      $finish;
   end

endmodule
